>>> rtl/tgb_pkg.sv
// Shared types, codes and constants for the text glyph blitter.
// Used by tgb_front, tgb_queue, tgb_back and text_glyph_blitter; no dependencies.
package tgb_pkg;

    localparam int GLYPH_SIZE  = 8;
    localparam int QUEUE_DEPTH = 4;

    // Item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_CHAR  = 1'b1;

    // Control character codes
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;

    // Configuration register indexes
    localparam logic [2:0] REG_FB_PRESENT  = 3'd0;
    localparam logic [2:0] REG_FB_WIDTH    = 3'd1;
    localparam logic [2:0] REG_FB_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_PITCH_WORDS = 3'd3;
    localparam logic [2:0] REG_BG_COLOR    = 3'd4;

    // Configuration reset values
    localparam logic [11:0] RST_FB_WIDTH    = 12'd640;
    localparam logic [11:0] RST_FB_HEIGHT   = 12'd480;
    localparam logic [12:0] RST_PITCH_WORDS = 13'd640;

    localparam logic signed [15:0] CURSOR_MAX = 16'sd32767;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        text_color;
        logic [7:0]         char_code;
        logic [63:0]        glyph_bits;
    } item_t;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic        fb_present;
        logic [11:0] fb_width;
        logic [11:0] fb_height;
        logic [12:0] pitch_words;
        logic [31:0] bg_color;
    } cfg_t;

    // One glyph ready to draw: visible window in glyph coordinates and the
    // word index of its top-left visible pixel.
    typedef struct packed {
        logic [63:0] glyph;
        logic [31:0] fg;
        logic [2:0]  col_first;
        logic [2:0]  col_last;
        logic [2:0]  row_first;
        logic [2:0]  row_last;
        logic [23:0] base_index;
    } job_t;

    typedef struct packed {
        logic emit;
        logic emit_last;
        logic pop;
    } back_stat_t;

endpackage

>>> rtl/text_glyph_blitter.sv
// Text glyph blitter top level: configuration registers, front end, job queue
// and pixel writer. Depends on tgb_pkg, tgb_front, tgb_queue and tgb_back.
//
// Usage:
//   item / item_valid / item_stall carry one item word: a start word (mode 0)
//   sets origin, cursor and foreground color; a character word (mode 1) is a
//   newline, a carriage return or a glyph to draw at the cursor.
//   pixel / pixel_valid / pixel_stall carry one framebuffer write per word,
//   with last_pixel set on the final write of a glyph. Fully clipped glyphs
//   and all glyphs while fb_present is 0 make no words; the cursor moves anyway.
//   cfg_we / cfg_index / cfg_data write a register while the block is idle.
// Timing:
//   Start, newline and carriage return words are taken one per cycle while
//   item_stall is low. A glyph is clipped in the cycle after it is taken,
//   then goes through the queue to the pixel writer's output register;
//   the writer issues one word per cycle while pixel_stall does not hold it.
//   The queue of QUEUE_DEPTH glyphs lets the front keep taking words while
//   the writer is busy.
// Reset clears the cursor, origin and foreground color, loads the register
// defaults and empties the queue. A stalled pixel word holds; the writer and,
// once the queue fills, the item channel stall behind it.
module text_glyph_blitter
#(
    parameter int QUEUE_DEPTH = tgb_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tgb_pkg::item_t  item,
    input  logic            item_valid,
    output logic            item_stall,
    output tgb_pkg::pixel_t pixel,
    output logic            pixel_valid,
    input  logic            pixel_stall,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    tgb_pkg::cfg_t       cfg_reg, cfg_next;
    tgb_pkg::job_t       job;
    tgb_pkg::job_t       head;
    logic                job_push;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    tgb_pkg::back_stat_t back_stat;

    // Register file: keep the low bits of each write, drop unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tgb_pkg::REG_FB_PRESENT:  cfg_next.fb_present  = cfg_data[0];
                tgb_pkg::REG_FB_WIDTH:    cfg_next.fb_width    = cfg_data[11:0];
                tgb_pkg::REG_FB_HEIGHT:   cfg_next.fb_height   = cfg_data[11:0];
                tgb_pkg::REG_PITCH_WORDS: cfg_next.pitch_words = cfg_data[12:0];
                tgb_pkg::REG_BG_COLOR:    cfg_next.bg_color    = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_present  <= 1'b0;
            cfg_reg.fb_width    <= tgb_pkg::RST_FB_WIDTH;
            cfg_reg.fb_height   <= tgb_pkg::RST_FB_HEIGHT;
            cfg_reg.pitch_words <= tgb_pkg::RST_PITCH_WORDS;
            cfg_reg.bg_color    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify items, advance the cursor, clip glyphs into jobs
    tgb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .job        (job),
        .job_push   (job_push),
        .q_full     (q_full)
    );

    tgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Expand the head job into pixel words
    tgb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (q_pop),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .stat        (back_stat)
    );

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into a full queue");

    a_emit_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.emit |-> !q_empty)
        else $error("pixel word issued with no queued job");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> back_stat.emit && back_stat.emit_last)
        else $error("job retired before its last pixel");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.emit |=> pixel_valid && (pixel.last_pixel == $past(back_stat.emit_last)))
        else $error("issued pixel word did not reach the output register");
`endif

endmodule

>>> rtl/tgb_front.sv
// Front end: accepts item words, tracks the cursor and clips each glyph.
// Depends on tgb_pkg; feeds jobs to tgb_queue.
module tgb_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  tgb_pkg::cfg_t  cfg,
    input  tgb_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_stall,
    output tgb_pkg::job_t  job,
    output logic           job_push,
    input  logic           q_full
);

    function automatic logic signed [15:0] sat_add8(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v > tgb_pkg::CURSOR_MAX - 16'sd8)
        begin
            r = tgb_pkg::CURSOR_MAX;
        end
        else
        begin
            r = v + 16'sd8;
        end
        return r;
    endfunction

    logic signed [15:0] origin_col_reg, origin_col_next;
    logic signed [15:0] cursor_col_reg, cursor_col_next;
    logic signed [15:0] cursor_row_reg, cursor_row_next;
    logic [31:0]        fg_color_reg, fg_color_next;

    logic               stage_valid_reg, stage_valid_next;
    logic signed [15:0] stage_col_reg, stage_col_next;
    logic signed [15:0] stage_row_reg, stage_row_next;
    logic [31:0]        stage_fg_reg, stage_fg_next;
    logic [63:0]        stage_glyph_reg, stage_glyph_next;

    logic               accept;
    logic               is_print;
    logic [16:0]        col_pos [tgb_pkg::GLYPH_SIZE];
    logic [16:0]        row_pos [tgb_pkg::GLYPH_SIZE];
    logic [7:0]         col_vis;
    logic [7:0]         row_vis;
    logic [2:0]         col_first, col_last, row_first, row_last;
    logic [11:0]        x0, y0;
    logic [24:0]        row_product;
    logic               visible;
    logic               stage_go;

    assign accept = item_valid && !item_stall;

    // Clip the staged glyph against the framebuffer
    always_comb
    begin
        for (int i = 0; i < tgb_pkg::GLYPH_SIZE; i++)
        begin
            col_pos[i] = 17'(stage_col_reg) + 17'(i);
            row_pos[i] = 17'(stage_row_reg) + 17'(i);
            col_vis[i] = !col_pos[i][16] && (col_pos[i][15:0] < {4'd0, cfg.fb_width});
            row_vis[i] = !row_pos[i][16] && (row_pos[i][15:0] < {4'd0, cfg.fb_height});
        end
        col_first = 3'd0;
        row_first = 3'd0;
        for (int i = tgb_pkg::GLYPH_SIZE - 1; i >= 0; i--)
        begin
            if (col_vis[i])
            begin
                col_first = 3'(i);
            end
            if (row_vis[i])
            begin
                row_first = 3'(i);
            end
        end
        col_last = 3'd0;
        row_last = 3'd0;
        for (int i = 0; i < tgb_pkg::GLYPH_SIZE; i++)
        begin
            if (col_vis[i])
            begin
                col_last = 3'(i);
            end
            if (row_vis[i])
            begin
                row_last = 3'(i);
            end
        end
    end

    assign x0          = stage_col_reg[11:0] + 12'(col_first);
    assign y0          = stage_row_reg[11:0] + 12'(row_first);
    assign row_product = 25'(y0) * 25'(cfg.pitch_words);
    assign visible     = cfg.fb_present && (|col_vis) && (|row_vis);

    // Drop fully clipped glyphs, hold when the queue is full
    assign stage_go   = !visible || !q_full;
    assign job_push   = stage_valid_reg && visible && !q_full;
    assign item_stall = stage_valid_reg && !stage_go;

    always_comb
    begin
        job.glyph      = stage_glyph_reg;
        job.fg         = stage_fg_reg;
        job.col_first  = col_first;
        job.col_last   = col_last;
        job.row_first  = row_first;
        job.row_last   = row_last;
        job.base_index = row_product[23:0] + {12'd0, x0};
    end

    always_comb
    begin
        origin_col_next  = origin_col_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        fg_color_next    = fg_color_reg;
        stage_valid_next = stage_valid_reg && !stage_go;
        stage_col_next   = stage_col_reg;
        stage_row_next   = stage_row_reg;
        stage_fg_next    = stage_fg_reg;
        stage_glyph_next = stage_glyph_reg;
        is_print         = 1'b0;

        if (item.mode == tgb_pkg::MODE_CHAR)
        begin
            case (item.char_code)
                tgb_pkg::CODE_NEWLINE,
                tgb_pkg::CODE_RETURN: is_print = 1'b0;
                default:              is_print = 1'b1;
            endcase
        end

        if (accept)
        begin
            if (item.mode == tgb_pkg::MODE_START)
            begin
                origin_col_next = item.pos_x;
                cursor_col_next = item.pos_x;
                cursor_row_next = item.pos_y;
                fg_color_next   = item.text_color;
            end
            else
            begin
                case (item.char_code)
                    tgb_pkg::CODE_NEWLINE:
                    begin
                        cursor_row_next = sat_add8(cursor_row_reg);
                        cursor_col_next = origin_col_reg;
                    end
                    tgb_pkg::CODE_RETURN:
                    begin
                        cursor_col_next = origin_col_reg;
                    end
                    default:
                    begin
                        cursor_col_next = sat_add8(cursor_col_reg);
                    end
                endcase
            end
            if (is_print)
            begin
                stage_valid_next = 1'b1;
                stage_col_next   = cursor_col_reg;
                stage_row_next   = cursor_row_reg;
                stage_fg_next    = fg_color_reg;
                stage_glyph_next = item.glyph_bits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_col_reg  <= '0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            fg_color_reg    <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            origin_col_reg  <= origin_col_next;
            cursor_col_reg  <= cursor_col_next;
            cursor_row_reg  <= cursor_row_next;
            fg_color_reg    <= fg_color_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_col_reg   <= stage_col_next;
        stage_row_reg   <= stage_row_next;
        stage_fg_reg    <= stage_fg_next;
        stage_glyph_reg <= stage_glyph_next;
    end

endmodule

>>> rtl/tgb_queue.sv
// Short job queue between the front end and the pixel writer.
// Depends on tgb_pkg for the job type.
module tgb_queue
#(
    parameter int DEPTH = tgb_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tgb_pkg::job_t push_data,
    input  logic          pop,
    output tgb_pkg::job_t head,
    output logic          empty,
    output logic          full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgb_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/tgb_back.sv
// Pixel writer: walks the visible window of the head job, one word per cycle
// when not stalled. Depends on tgb_pkg; reads jobs from tgb_queue.
module tgb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tgb_pkg::cfg_t       cfg,
    input  tgb_pkg::job_t       head,
    input  logic                q_empty,
    output logic                pop,
    output tgb_pkg::pixel_t     pixel,
    output logic                pixel_valid,
    input  logic                pixel_stall,
    output tgb_pkg::back_stat_t stat
);

    logic            active_reg, active_next;
    logic [2:0]      row_reg, row_next;
    logic [2:0]      col_reg, col_next;
    logic [23:0]     row_base_reg, row_base_next;
    logic [23:0]     index_reg, index_next;
    logic            out_valid_reg, out_valid_next;
    tgb_pkg::pixel_t out_reg, out_next;

    logic [2:0]      cur_row, cur_col;
    logic [23:0]     cur_base, cur_index;
    logic            emit, end_of_row, end_of_job;
    logic [31:0]     color;

    // Start a fresh job from the head entry itself
    assign cur_row    = active_reg ? row_reg : head.row_first;
    assign cur_col    = active_reg ? col_reg : head.col_first;
    assign cur_base   = active_reg ? row_base_reg : head.base_index;
    assign cur_index  = active_reg ? index_reg : head.base_index;

    assign emit       = !q_empty && (!out_valid_reg || !pixel_stall);
    assign end_of_row = (cur_col == head.col_last);
    assign end_of_job = end_of_row && (cur_row == head.row_last);
    assign pop        = emit && end_of_job;
    assign color      = head.glyph[{~cur_row, ~cur_col}] ? head.fg : cfg.bg_color;

    assign pixel       = out_reg;
    assign pixel_valid = out_valid_reg;

    assign stat.emit      = emit;
    assign stat.emit_last = end_of_job;
    assign stat.pop       = pop;

    always_comb
    begin
        active_next    = active_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        row_base_next  = row_base_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg && pixel_stall;
        out_next       = out_reg;
        if (emit)
        begin
            active_next          = !end_of_job;
            out_valid_next       = 1'b1;
            out_next.pixel_index = cur_index;
            out_next.pixel_color = color;
            out_next.last_pixel  = end_of_job;
            if (end_of_row)
            begin
                row_next      = cur_row + 3'd1;
                col_next      = head.col_first;
                row_base_next = cur_base + {11'd0, cfg.pitch_words};
                index_next    = cur_base + {11'd0, cfg.pitch_words};
            end
            else
            begin
                row_next      = cur_row;
                col_next      = cur_col + 3'd1;
                row_base_next = cur_base;
                index_next    = cur_index + 24'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        row_base_reg <= row_base_next;
        index_reg    <= index_next;
        out_reg      <= out_next;
    end

endmodule

>>> tb/text_glyph_blitter_tb.sv
// Self-checking testbench for text_glyph_blitter: drives start and character words,
// predicts every framebuffer write and checks the pixel channel in order.
// Depends on tgb_pkg and the text_glyph_blitter RTL.
module text_glyph_blitter_tb;

    // Receiver hold-off used to back the block up into its item channel.
    localparam int HOLD_CYCLES   = 600;
    // Quiet time after the last expected write before registers change.
    localparam int SETTLE_CYCLES = tgb_pkg::GLYPH_SIZE * tgb_pkg::GLYPH_SIZE *
                                   (tgb_pkg::QUEUE_DEPTH + 3);
    localparam int DRAIN_LIMIT   = 40000;
    localparam int RUN_LIMIT     = 800000;

    // Scoreboard: carries its own copy of the cursor state and the registers,
    // expands each accepted word into the writes it should cause and matches
    // them against the pixel channel, oldest first.
    class blit_scoreboard;
        tgb_pkg::cfg_t      regs;
        logic signed [15:0] origin_col;
        logic signed [15:0] cursor_col;
        logic signed [15:0] cursor_row;
        logic [31:0]        fg_color;
        tgb_pkg::pixel_t    due_writes[$];
        int                 faults;
        int                 reports;

        function new();
            regs = '{fb_present: 1'b0, fb_width: tgb_pkg::RST_FB_WIDTH,
                     fb_height: tgb_pkg::RST_FB_HEIGHT,
                     pitch_words: tgb_pkg::RST_PITCH_WORDS, bg_color: 32'd0};
            origin_col = '0;
            cursor_col = '0;
            cursor_row = '0;
            fg_color   = '0;
            faults     = 0;
            reports    = 0;
        endfunction

        // Keep only as many bits as the register holds; unused indexes do nothing.
        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                tgb_pkg::REG_FB_PRESENT:  regs.fb_present  = data[0];
                tgb_pkg::REG_FB_WIDTH:    regs.fb_width    = data[11:0];
                tgb_pkg::REG_FB_HEIGHT:   regs.fb_height   = data[11:0];
                tgb_pkg::REG_PITCH_WORDS: regs.pitch_words = data[12:0];
                tgb_pkg::REG_BG_COLOR:    regs.bg_color    = data;
                default: ;
            endcase
        endfunction

        // Advance one glyph cell, pinned at the top of the signed range.
        function logic signed [15:0] step_cell(logic signed [15:0] v);
            int s;
            s = int'(v) + tgb_pkg::GLYPH_SIZE;
            return (s > int'(tgb_pkg::CURSOR_MAX)) ? tgb_pkg::CURSOR_MAX : 16'(s);
        endfunction

        function void expand_word(tgb_pkg::item_t w);
            int              py;
            int              px;
            int              h;
            int              wd;
            int              pitch;
            logic [31:0]     idx;
            tgb_pkg::pixel_t wr;
            tgb_pkg::pixel_t glyph_px[$];
            if (w.mode == tgb_pkg::MODE_START)
            begin
                origin_col = w.pos_x;
                cursor_col = w.pos_x;
                cursor_row = w.pos_y;
                fg_color   = w.text_color;
                return;
            end
            if (w.char_code == tgb_pkg::CODE_NEWLINE)
            begin
                cursor_row = step_cell(cursor_row);
                cursor_col = origin_col;
                return;
            end
            if (w.char_code == tgb_pkg::CODE_RETURN)
            begin
                cursor_col = origin_col;
                return;
            end
            if (regs.fb_present)
            begin
                h     = regs.fb_height;
                wd    = regs.fb_width;
                pitch = regs.pitch_words;
                // Top row first, leftmost pixel first; drop anything off screen.
                for (int row = 0; row < tgb_pkg::GLYPH_SIZE; row++)
                begin
                    py = int'(cursor_row) + row;
                    if (py < 0 || py >= h)
                        continue;
                    for (int col = 0; col < tgb_pkg::GLYPH_SIZE; col++)
                    begin
                        px = int'(cursor_col) + col;
                        if (px < 0 || px >= wd)
                            continue;
                        idx = py * pitch + px;
                        wr.pixel_index = idx[23:0];
                        wr.pixel_color = w.glyph_bits[63 - tgb_pkg::GLYPH_SIZE * row - col] ?
                                         fg_color : regs.bg_color;
                        wr.last_pixel  = 1'b0;
                        glyph_px.push_back(wr);
                    end
                end
                if (glyph_px.size() > 0)
                    glyph_px[glyph_px.size() - 1].last_pixel = 1'b1;
                foreach (glyph_px[i])
                    due_writes.push_back(glyph_px[i]);
            end
            // The cursor moves even when nothing was drawn.
            cursor_col = step_cell(cursor_col);
        endfunction

        function void note_fault(string what, tgb_pkg::pixel_t want, tgb_pkg::pixel_t got);
            if (reports < 10)
                $display("%s: expected index %h color %h last %b, got index %h color %h last %b",
                         what, want.pixel_index, want.pixel_color, want.last_pixel,
                         got.pixel_index, got.pixel_color, got.last_pixel);
            reports++;
            faults++;
        endfunction

        function void check_write(tgb_pkg::pixel_t got);
            tgb_pkg::pixel_t want;
            if (due_writes.size() == 0)
            begin
                want = '0;
                note_fault("unexpected write", want, got);
                return;
            end
            want = due_writes.pop_front();
            if (got.pixel_index !== want.pixel_index || got.pixel_color !== want.pixel_color ||
                got.last_pixel !== want.last_pixel)
                note_fault("write mismatch", want, got);
        endfunction
    endclass

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    tgb_pkg::item_t  item        = '0;
    logic            item_valid  = 1'b0;
    logic            item_stall;
    tgb_pkg::pixel_t pixel;
    logic            pixel_valid;
    logic            pixel_stall = 1'b0;
    logic            cfg_we      = 1'b0;
    logic [2:0]      cfg_index   = '0;
    logic [31:0]     cfg_data    = '0;

    // calm turns off random idling on both sides; hold_asks asks the
    // receiver for one long hold-off.
    bit          calm      = 1'b0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_left = 0;

    blit_scoreboard sb = new();

    text_glyph_blitter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pixel receiver: check each accepted word, then pick next cycle's stall.
    // A pending hold request wins over random stalls and is counted down here.
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            sb.check_write(pixel);
        if (hold_left > 0)
        begin
            hold_left   = hold_left - 1;
            pixel_stall <= 1'b1;
        end
        else if (hold_done != hold_asks)
        begin
            hold_done   = hold_done + 1;
            hold_left   = HOLD_CYCLES;
            pixel_stall <= 1'b1;
        end
        else
        begin
            pixel_stall <= !calm && ($urandom_range(99) < 12);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one item word, optionally after a random gap, and hold it until taken.
    // Feed the prediction only once the handshake has completed.
    task automatic push_word(tgb_pkg::item_t w);
        if (!calm && $urandom_range(99) < 12)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.expand_word(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Load every register; junk above each register's width must be dropped.
    task automatic load_regs(tgb_pkg::cfg_t c);
        write_reg(tgb_pkg::REG_FB_PRESENT, ($urandom << 1) | c.fb_present);
        write_reg(tgb_pkg::REG_FB_WIDTH, ($urandom << 12) | c.fb_width);
        write_reg(tgb_pkg::REG_FB_HEIGHT, ($urandom << 12) | c.fb_height);
        write_reg(tgb_pkg::REG_PITCH_WORDS, ($urandom << 13) | c.pitch_words);
        write_reg(tgb_pkg::REG_BG_COLOR, c.bg_color);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every predicted write, then give glyphs that make
    // no writes time to leave the pipeline before registers change.
    task automatic settle();
        int spins;
        spins = 0;
        item_valid <= 1'b0;
        while (sb.due_writes.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (sb.due_writes.size() != 0)
        begin
            $display("%0d expected writes never arrived", sb.due_writes.size());
            sb.faults += sb.due_writes.size();
            sb.due_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Start words carry junk in the character fields and vice versa; the block
    // must ignore whichever half does not apply.
    function automatic tgb_pkg::item_t start_word(logic signed [15:0] x,
                                                  logic signed [15:0] y,
                                                  logic [31:0] color);
        tgb_pkg::item_t w;
        w.mode       = tgb_pkg::MODE_START;
        w.pos_x      = x;
        w.pos_y      = y;
        w.text_color = color;
        w.char_code  = 8'($urandom);
        w.glyph_bits = {$urandom, $urandom};
        return w;
    endfunction

    function automatic tgb_pkg::item_t char_word(logic [7:0] code, logic [63:0] glyph);
        tgb_pkg::item_t w;
        w.mode       = tgb_pkg::MODE_CHAR;
        w.pos_x      = 16'($urandom);
        w.pos_y      = 16'($urandom);
        w.text_color = $urandom;
        w.char_code  = code;
        w.glyph_bits = glyph;
        return w;
    endfunction

    // Random strings: a start word, mostly near the visible area, followed by
    // a short run of characters with the odd newline or carriage return.
    task automatic tell_story(int words);
        int          sent;
        int          wd;
        int          ht;
        int          x;
        int          y;
        int          pick;
        logic [7:0]  code;
        logic [63:0] glyph;
        sent = 0;
        while (sent < words)
        begin
            wd = sb.regs.fb_width;
            ht = sb.regs.fb_height;
            if ($urandom_range(99) < 80)
            begin
                x = $urandom_range(wd + 10) - 8;
                y = $urandom_range(ht + 10) - 8;
            end
            else
            begin
                x = $urandom_range(65535) - 32768;
                y = $urandom_range(65535) - 32768;
            end
            push_word(start_word(16'(x), 16'(y), $urandom));
            sent++;
            repeat ($urandom_range(1, 12))
            begin
                pick = $urandom_range(99);
                code = 8'($urandom);
                if (pick < 7)
                    code = tgb_pkg::CODE_NEWLINE;
                else if (pick < 12)
                    code = tgb_pkg::CODE_RETURN;
                pick  = $urandom_range(9);
                glyph = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
                push_word(char_word(code, glyph));
                sent++;
            end
        end
    endtask

    // One random phase: fresh registers, then strings. quiet drops all idling,
    // squeeze asks the receiver for a long hold-off while strings keep coming.
    task automatic random_phase(int words, bit quiet, bit squeeze);
        tgb_pkg::cfg_t c;
        c.fb_present  = ($urandom_range(9) != 0);
        c.fb_width    = 12'($urandom_range(8, 320));
        c.fb_height   = 12'($urandom_range(8, 240));
        c.pitch_words = ($urandom_range(3) == 0) ? 13'($urandom) :
                        13'(c.fb_width + $urandom_range(64));
        c.bg_color    = $urandom;
        load_regs(c);
        calm = quiet;
        if (squeeze)
            hold_asks++;
        tell_story(words);
        calm = 1'b0;
        settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers leave the framebuffer absent: the cursor moves, nothing draws.
        push_word(start_word(16'sd5, 16'sd3, 32'h00FF_00FF));
        push_word(char_word(8'h41, {$urandom, $urandom}));
        settle();

        // Writes to unused indexes must not disturb anything.
        for (int k = tgb_pkg::REG_BG_COLOR + 1; k < 8; k++)
            write_reg(3'(k), $urandom);
        load_regs('{1'b1, 12'd40, 12'd30, 13'd48, 32'h0000_00AA});

        // Clipped at top-left, all-on, all-off, code zero, code 255, returns.
        push_word(start_word(-16'sd4, -16'sd3, 32'hC0DE_0001));
        push_word(char_word(8'h7F, '1));
        push_word(char_word(8'h00, 64'd0));
        push_word(char_word(8'hFF, 64'h8040_2010_0804_0201));
        push_word(char_word(tgb_pkg::CODE_RETURN, '1));
        push_word(char_word(tgb_pkg::CODE_NEWLINE, '1));
        push_word(char_word(8'h20, 64'hAA55_AA55_AA55_AA55));
        // Clipped at bottom-right.
        push_word(start_word(16'sd36, 16'sd26, 32'hC0DE_0002));
        push_word(char_word(8'h42, {$urandom, $urandom}));
        // Fully off screen: no writes, cursor still advances.
        push_word(start_word(16'sd100, 16'sd100, 32'hC0DE_0003));
        push_word(char_word(8'h43, '1));
        // Column saturation at the right end of the range.
        push_word(start_word(16'sd32764, 16'sd0, 32'hC0DE_0004));
        push_word(char_word(8'h44, {$urandom, $urandom}));
        push_word(char_word(8'h45, {$urandom, $urandom}));
        // Row saturation through a newline.
        push_word(start_word(16'sd0, 16'sd32765, 32'hC0DE_0005));
        push_word(char_word(tgb_pkg::CODE_NEWLINE, 64'd0));
        // Most negative origin.
        push_word(start_word(16'sh8000, 16'sh8000, 32'hC0DE_0006));
        push_word(char_word(8'h46, '1));
        // Fully visible glyph.
        push_word(start_word(16'sd8, 16'sd8, 32'hC0DE_0007));
        push_word(char_word(8'h47, {$urandom, $urandom}));
        settle();

        // Largest sizes: the word index wraps past 24 bits.
        load_regs('{1'b1, 12'd4095, 12'd4095, 13'd8191, 32'hFFFF_FFFF});
        push_word(start_word(16'sd4088, 16'sd4088, 32'h1234_5678));
        push_word(char_word(8'h48, {$urandom, $urandom}));
        push_word(start_word(16'sd0, 16'sd4000, 32'h8765_4321));
        push_word(char_word(8'h49, 64'hAAAA_AAAA_5555_5555));
        settle();

        // Zero sizes: everything is clipped.
        load_regs('{1'b1, 12'd0, 12'd0, 13'd0, 32'h0});
        push_word(char_word(8'h4A, '1));
        settle();

        random_phase(45, 1'b0, 1'b0);
        random_phase(45, 1'b1, 1'b0);
        random_phase(45, 1'b0, 1'b1);
        random_phase(40, 1'b0, 1'b0);
        random_phase(40, 1'b0, 1'b0);

        if (sb.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
